### rtl/dst_pkg.sv
// Package for the daily schedule trigger.
// Word types, plan entry layout, command and result codes, control/status bundles.
// No dependencies.
package dst_pkg;

   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_LOAD = 2'd1;
   localparam logic [1:0] CMD_SET  = 2'd2;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_FEED   = 1'b1;

   localparam int FEED_CNT_W = 4;
   localparam logic [FEED_CNT_W-1:0] MAX_FEEDS = 4'd8;

   localparam logic [5:0] SEC_LIMIT  = 6'd60;
   localparam logic [5:0] MIN_LIMIT  = 6'd60;
   localparam logic [4:0] HOUR_LIMIT = 5'd24;

   typedef struct packed {
      logic [1:0]  command;
      logic [2:0]  plan_index;
      logic [3:0]  device;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [15:0] run_length;
      logic [3:0]  start_month;
      logic [4:0]  start_day;
      logic [3:0]  stop_month;
      logic [4:0]  stop_day;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  feed_device;
      logic [15:0] feed_length;
      logic [4:0]  now_hour;
      logic [5:0]  now_minute;
      logic [5:0]  now_second;
      logic        day_end;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  device;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [15:0] length;
      logic [3:0]  b_month;
      logic [4:0]  b_day;
      logic [3:0]  e_month;
      logic [4:0]  e_day;
   } plan_type;

   typedef struct packed {
      logic take_req;
      logic scan_rd;
      logic scan_ev;
      logic send_feed;
      logic send_status;
      logic idx_clear;
      logic idx_step;
   } ctrl_type;

   typedef struct packed {
      logic req_tick;
      logic fire_emit;
      logic idx_last;
      logic out_free;
   } stat_type;

endpackage

### rtl/dst_ctrl.sv
// Sequencer for the daily schedule trigger.
// Steps accept, plan scan, feed and status emission; drives dst_pkg::ctrl_type.
// Depends on dst_pkg.
module dst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  dst_pkg::stat_type stat,
   output dst_pkg::ctrl_type ctrl,
   output logic              req_stall
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_READ   = 5'b00010,
      ST_EVAL   = 5'b00100,
      ST_EMIT   = 5'b01000,
      ST_STATUS = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.take_req = 1'b1;
               if (stat.req_tick) begin
                  ctrl.idx_clear = 1'b1;
                  state_in       = ST_READ;
               end else begin
                  state_in = ST_STATUS;
               end
            end
         end
         ST_READ: begin
            ctrl.scan_rd = 1'b1;
            state_in     = ST_EVAL;
         end
         ST_EVAL: begin
            ctrl.scan_ev = 1'b1;
            if (stat.fire_emit) begin
               state_in = ST_EMIT;
            end else if (stat.idx_last) begin
               state_in = ST_STATUS;
            end else begin
               ctrl.idx_step = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               ctrl.send_feed = 1'b1;
               if (stat.idx_last) begin
                  state_in = ST_STATUS;
               end else begin
                  ctrl.idx_step = 1'b1;
                  state_in      = ST_READ;
               end
            end
         end
         ST_STATUS: begin
            if (stat.out_free) begin
               ctrl.send_status = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

### rtl/dst_datapath.sv
// Datapath for the daily schedule trigger.
// Clock and date registers, plan and count memories, slot flags, output word register.
// Depends on dst_pkg.
module dst_datapath #(
   parameter int PLAN_SLOTS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  dst_pkg::req_type  req,
   input  dst_pkg::ctrl_type ctrl,
   output dst_pkg::stat_type stat,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output dst_pkg::rsp_type  rsp
);

   localparam int SLOT_W = (PLAN_SLOTS > 1) ? $clog2(PLAN_SLOTS) : 1;

   logic [4:0] hour_ff, hour_in;
   logic [5:0] min_ff, min_in;
   logic [5:0] sec_ff, sec_in;
   logic [3:0] month_ff, month_in;
   logic [4:0] day_ff, day_in;
   logic       dayend_ff, dayend_in;

   logic [4:0] t_hour;
   logic [5:0] t_min;
   logic [5:0] t_sec;
   logic       t_dayend;

   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [dst_pkg::FEED_CNT_W-1:0] feed_cnt_ff, feed_cnt_in;
   logic [PLAN_SLOTS-1:0] valid_ff, valid_in;
   logic [PLAN_SLOTS-1:0] active_ff, active_in;

   dst_pkg::plan_type plan_mem [PLAN_SLOTS];
   logic [15:0]       elap_mem [PLAN_SLOTS];
   dst_pkg::plan_type plan_rd_ff;
   logic [15:0]       elap_rd_ff;

   dst_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic              load_hit;
   logic [SLOT_W-1:0] wr_idx;
   dst_pkg::plan_type wr_plan;
   logic              cur_valid;
   logic              cur_active;
   logic              after_begin;
   logic              before_end;
   logic              fire;
   logic [15:0]       elap_inc;
   logic              run_done;
   logic              out_free;

   // one-second advance with carries
   always_comb begin
      t_sec    = sec_ff + 6'd1;
      t_min    = min_ff;
      t_hour   = hour_ff;
      t_dayend = 1'b0;
      if (t_sec >= dst_pkg::SEC_LIMIT) begin
         t_sec = '0;
         t_min = min_ff + 6'd1;
      end
      if (t_min >= dst_pkg::MIN_LIMIT) begin
         t_min  = '0;
         t_hour = hour_ff + 5'd1;
      end
      if (t_hour >= dst_pkg::HOUR_LIMIT) begin
         t_hour   = '0;
         t_dayend = 1'b1;
      end
   end

   always_comb begin
      hour_in   = hour_ff;
      min_in    = min_ff;
      sec_in    = sec_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      dayend_in = dayend_ff;
      if (ctrl.take_req) begin
         case (req.command)
            dst_pkg::CMD_TICK: begin
               hour_in   = t_hour;
               min_in    = t_min;
               sec_in    = t_sec;
               dayend_in = t_dayend;
            end
            dst_pkg::CMD_SET: begin
               hour_in   = req.hour;
               min_in    = req.minute;
               sec_in    = req.second;
               month_in  = req.start_month;
               day_in    = req.start_day;
               dayend_in = 1'b0;
            end
            default: begin
               dayend_in = 1'b0;
            end
         endcase
      end
   end

   assign load_hit = ctrl.take_req && (req.command == dst_pkg::CMD_LOAD) &&
                     (int'(req.plan_index) < PLAN_SLOTS);
   assign wr_idx   = SLOT_W'(req.plan_index);

   always_comb begin
      wr_plan.device  = req.device;
      wr_plan.hour    = req.hour;
      wr_plan.minute  = req.minute;
      wr_plan.length  = req.run_length;
      wr_plan.b_month = req.start_month;
      wr_plan.b_day   = req.start_day;
      wr_plan.e_month = req.stop_month;
      wr_plan.e_day   = req.stop_day;
   end

   assign cur_valid   = valid_ff[idx_ff];
   assign cur_active  = active_ff[idx_ff];
   assign after_begin = (month_ff > plan_rd_ff.b_month) ||
                        ((month_ff == plan_rd_ff.b_month) && (day_ff >= plan_rd_ff.b_day));
   assign before_end  = (month_ff < plan_rd_ff.e_month) ||
                        ((month_ff == plan_rd_ff.e_month) && (day_ff <= plan_rd_ff.e_day));
   assign fire        = cur_valid && !cur_active && after_begin && before_end &&
                        (hour_ff == plan_rd_ff.hour) && (min_ff == plan_rd_ff.minute);
   assign elap_inc    = elap_rd_ff + 16'd1;
   assign run_done    = (elap_inc >= plan_rd_ff.length) || (elap_inc == 16'd0);

   always_comb begin
      valid_in  = valid_ff;
      active_in = active_ff;
      if (load_hit) begin
         valid_in[wr_idx]  = 1'b1;
         active_in[wr_idx] = 1'b0;
      end
      if (ctrl.scan_ev && cur_valid) begin
         if (!cur_active) begin
            if (fire) begin
               active_in[idx_ff] = 1'b1;
            end
         end else if (run_done) begin
            active_in[idx_ff] = 1'b0;
         end
      end
   end

   // plan table and run counts, one write and one registered read each
   always_ff @(posedge clock) begin
      if (load_hit) begin
         plan_mem[wr_idx] <= wr_plan;
      end
      if (ctrl.scan_rd) begin
         plan_rd_ff <= plan_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.scan_ev && cur_valid) begin
         if (!cur_active) begin
            if (fire) begin
               elap_mem[idx_ff] <= '0;
            end
         end else if (run_done) begin
            elap_mem[idx_ff] <= '0;
         end else begin
            elap_mem[idx_ff] <= elap_inc;
         end
      end
      if (ctrl.scan_rd) begin
         elap_rd_ff <= elap_mem[idx_ff];
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (ctrl.idx_clear) begin
         idx_in = '0;
      end else if (ctrl.idx_step) begin
         idx_in = idx_ff + SLOT_W'(1);
      end
   end

   always_comb begin
      feed_cnt_in = feed_cnt_ff;
      if (ctrl.take_req) begin
         feed_cnt_in = '0;
      end else if (ctrl.send_feed) begin
         feed_cnt_in = feed_cnt_ff + dst_pkg::FEED_CNT_W'(1);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctrl.send_feed || ctrl.send_status) begin
         rsp_valid_in       = 1'b1;
         rsp_in.now_hour    = hour_ff;
         rsp_in.now_minute  = min_ff;
         rsp_in.now_second  = sec_ff;
         rsp_in.day_end     = dayend_ff;
         if (ctrl.send_feed) begin
            rsp_in.kind        = dst_pkg::KIND_FEED;
            rsp_in.feed_device = plan_rd_ff.device;
            rsp_in.feed_length = plan_rd_ff.length;
            rsp_in.last        = 1'b0;
         end else begin
            rsp_in.kind        = dst_pkg::KIND_STATUS;
            rsp_in.feed_device = '0;
            rsp_in.feed_length = '0;
            rsp_in.last        = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff      <= '0;
         min_ff       <= '0;
         sec_ff       <= '0;
         month_ff     <= 4'd1;
         day_ff       <= 5'd1;
         dayend_ff    <= 1'b0;
         idx_ff       <= '0;
         feed_cnt_ff  <= '0;
         valid_ff     <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hour_ff      <= hour_in;
         min_ff       <= min_in;
         sec_ff       <= sec_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
         dayend_ff    <= dayend_in;
         idx_ff       <= idx_in;
         feed_cnt_ff  <= feed_cnt_in;
         valid_ff     <= valid_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign stat.req_tick  = (req.command == dst_pkg::CMD_TICK);
   assign stat.fire_emit = fire && (feed_cnt_ff < dst_pkg::MAX_FEEDS);
   assign stat.idx_last  = (idx_ff == SLOT_W'(PLAN_SLOTS - 1));
   assign stat.out_free  = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### rtl/daily_schedule_trigger.sv
// Daily schedule trigger: time-of-day clock, date and plan table with feed triggers.
// Request word in on req_, result words out on rsp_, valid/stall handshake on both.
// Usage:
//   A word is taken when req_valid is high and req_stall low. A tick advances the
//   clock one second and then scans the plan slots in order; each firing plan
//   gives a feed word (at most eight per tick), and every command ends with one
//   status word that carries last = 1. Load writes a plan slot; set loads clock
//   and date.
//   Load, set and unknown commands go from accept straight to the status word.
//   A tick scans the slots one at a time through the single read port of the plan
//   table (address, then evaluate), with an emit step for each feed word. req_stall
//   is high from accept until the status word is loaded into the output register.
//   The output register holds a word until it is taken; while it is full and rsp_stall
//   is high the scan halts at the next word to send and nothing is lost.
//   Reset (synchronous) clears the clock to 00:00:00, the date to month 1 day 1,
//   all plan slots to invalid and idle, and empties the output register.
module daily_schedule_trigger #(
   parameter int PLAN_SLOTS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dst_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dst_pkg::rsp_type rsp
);

   dst_pkg::ctrl_type ctrl;
   dst_pkg::stat_type stat;

   dst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .ctrl      (ctrl),
      .req_stall (req_stall)
   );

   dst_datapath #(
      .PLAN_SLOTS (PLAN_SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .ctrl      (ctrl),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   a_last_on_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.last == (rsp.kind == dst_pkg::KIND_STATUS)))
      else $error("last flag does not match word kind");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request port open right after accept");

   a_status_no_feed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp.kind == dst_pkg::KIND_STATUS)) |->
      ((rsp.feed_device == 4'd0) && (rsp.feed_length == 16'd0)))
      else $error("status word carries feed data");

   a_hold_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
      else $error("stalled result word dropped or changed");

endmodule

### bench/schedule_checker.sv
`timescale 1ns / 100ps
// Checker for the daily schedule trigger: tracks clock, date and plan slots from accepted
// request words and compares each result word, in order, with the predicted one.
// Depends on dst_pkg; instantiated beside the block by tb.
module schedule_checker #(
   parameter int PLAN_SLOTS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  dst_pkg::req_type req,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  dst_pkg::rsp_type rsp,
   output int               failures,
   output int               pending
);

   logic [4:0]  tod_hour;
   logic [5:0]  tod_minute;
   logic [5:0]  tod_second;
   logic [3:0]  date_month;
   logic [4:0]  date_day;
   dst_pkg::plan_type plans [PLAN_SLOTS];
   logic        slot_valid [PLAN_SLOTS];
   logic        slot_running [PLAN_SLOTS];
   logic [15:0] slot_ticks [PLAN_SLOTS];
   dst_pkg::rsp_type expected_words [$];
   int          mismatch_count = 0;
   int          words_due = 0;

   assign failures = mismatch_count;
   assign pending  = words_due;

   function automatic logic date_in_window(input dst_pkg::plan_type p);
      logic after_begin;
      logic before_end;
      after_begin = date_month > p.b_month ||
                    (date_month == p.b_month && date_day >= p.b_day);
      before_end  = date_month < p.e_month ||
                    (date_month == p.e_month && date_day <= p.e_day);
      return after_begin && before_end;
   endfunction

   function automatic dst_pkg::rsp_type clock_word(input logic kind, input logic [3:0] dev,
                                                   input logic [15:0] len,
                                                   input logic day_wrap,
                                                   input logic fin);
      dst_pkg::rsp_type r;
      r.kind        = kind;
      r.feed_device = dev;
      r.feed_length = len;
      r.now_hour    = tod_hour;
      r.now_minute  = tod_minute;
      r.now_second  = tod_second;
      r.day_end     = day_wrap;
      r.last        = fin;
      return r;
   endfunction

   task automatic predict_schedule(input dst_pkg::req_type w);
      logic day_wrap;
      int   fed;
      day_wrap = 1'b0;
      fed      = 0;
      case (w.command)
         dst_pkg::CMD_TICK: begin
            tod_second = tod_second + 6'd1;
            if (tod_second >= dst_pkg::SEC_LIMIT) begin
               tod_second = '0;
               tod_minute = tod_minute + 6'd1;
            end
            if (tod_minute >= dst_pkg::MIN_LIMIT) begin
               tod_minute = '0;
               tod_hour   = tod_hour + 5'd1;
            end
            if (tod_hour >= dst_pkg::HOUR_LIMIT) begin
               day_wrap = 1'b1;
               tod_hour = '0;
            end
            for (int i = 0; i < PLAN_SLOTS; i++) begin
               if (slot_valid[i] && !slot_running[i]) begin
                  if (date_in_window(plans[i]) && tod_hour == plans[i].hour &&
                      tod_minute == plans[i].minute) begin
                     slot_running[i] = 1'b1;
                     slot_ticks[i]   = '0;
                     if (fed < dst_pkg::MAX_FEEDS) begin
                        expected_words.push_back(clock_word(dst_pkg::KIND_FEED,
                                                            plans[i].device,
                                                            plans[i].length, day_wrap,
                                                            1'b0));
                        fed++;
                     end
                  end
               end else if (slot_valid[i]) begin
                  slot_ticks[i] = slot_ticks[i] + 16'd1;
                  if (slot_ticks[i] >= plans[i].length || slot_ticks[i] == 16'd0) begin
                     slot_running[i] = 1'b0;
                     slot_ticks[i]   = '0;
                  end
               end
            end
         end
         dst_pkg::CMD_LOAD: begin
            if (w.plan_index < PLAN_SLOTS) begin
               plans[w.plan_index].device  = w.device;
               plans[w.plan_index].hour    = w.hour;
               plans[w.plan_index].minute  = w.minute;
               plans[w.plan_index].length  = w.run_length;
               plans[w.plan_index].b_month = w.start_month;
               plans[w.plan_index].b_day   = w.start_day;
               plans[w.plan_index].e_month = w.stop_month;
               plans[w.plan_index].e_day   = w.stop_day;
               slot_valid[w.plan_index]    = 1'b1;
               slot_running[w.plan_index]  = 1'b0;
               slot_ticks[w.plan_index]    = '0;
            end
         end
         dst_pkg::CMD_SET: begin
            tod_hour   = w.hour;
            tod_minute = w.minute;
            tod_second = w.second;
            date_month = w.start_month;
            date_day   = w.start_day;
         end
         default: begin
         end
      endcase
      expected_words.push_back(clock_word(dst_pkg::KIND_STATUS, 4'd0, 16'd0, day_wrap,
                                          1'b1));
   endtask

   always @(posedge clock) begin
      dst_pkg::rsp_type want;
      if (reset) begin
         tod_hour   = '0;
         tod_minute = '0;
         tod_second = '0;
         date_month = 4'd1;
         date_day   = 5'd1;
         for (int i = 0; i < PLAN_SLOTS; i++) begin
            slot_valid[i]   = 1'b0;
            slot_running[i] = 1'b0;
            slot_ticks[i]   = '0;
         end
         expected_words.delete();
      end else begin
         if (req_valid && !req_stall) begin
            predict_schedule(req);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("rsp word with none expected: %h", rsp);
               end
            end else begin
               want = expected_words.pop_front();
               if (rsp !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("rsp mismatch, kind/dev/len time day_end last");
                     $display("  expected %0d/%0d/%0d %0d:%0d:%0d %0d %0d",
                              want.kind, want.feed_device, want.feed_length, want.now_hour,
                              want.now_minute, want.now_second, want.day_end, want.last);
                     $display("  actual   %0d/%0d/%0d %0d:%0d:%0d %0d %0d",
                              rsp.kind, rsp.feed_device, rsp.feed_length, rsp.now_hour,
                              rsp.now_minute, rsp.now_second, rsp.day_end, rsp.last);
                  end
               end
            end
         end
      end
      words_due = expected_words.size();
   end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Bench top for the daily schedule trigger: clock, reset, request stimulus, result stalls
// and the verdict. Depends on dst_pkg, daily_schedule_trigger and schedule_checker.
module tb;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int PLAN_SLOTS   = 8;
   localparam int RANDOM_WORDS = 250;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 300000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   dst_pkg::req_type req = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   dst_pkg::rsp_type rsp;
   int      failures;
   int      pending;
   int      cycle_count = 0;
   int      burst_left = 0;
   int      sent_words = 0;
   bit      hold_ask = 1'b0;

   daily_schedule_trigger #(.PLAN_SLOTS(PLAN_SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   schedule_checker #(.PLAN_SLOTS(PLAN_SLOTS)) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .failures  (failures),
      .pending   (pending)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic dst_pkg::req_type noise_word();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(dst_pkg::req_type)-1:0];
   endfunction

   function automatic dst_pkg::req_type tick_word();
      dst_pkg::req_type w;
      w = noise_word();
      w.command = dst_pkg::CMD_TICK;
      return w;
   endfunction

   function automatic dst_pkg::req_type load_word(input int slot, input int dev, input int h,
                                                  input int m, input int len, input int bm,
                                                  input int bd, input int em, input int ed);
      dst_pkg::req_type w;
      w = noise_word();
      w.command     = dst_pkg::CMD_LOAD;
      w.plan_index  = slot[2:0];
      w.device      = dev[3:0];
      w.hour        = h[4:0];
      w.minute      = m[5:0];
      w.run_length  = len[15:0];
      w.start_month = bm[3:0];
      w.start_day   = bd[4:0];
      w.stop_month  = em[3:0];
      w.stop_day    = ed[4:0];
      return w;
   endfunction

   function automatic dst_pkg::req_type set_word(input int h, input int m, input int s,
                                                 input int mon, input int dy);
      dst_pkg::req_type w;
      w = noise_word();
      w.command     = dst_pkg::CMD_SET;
      w.hour        = h[4:0];
      w.minute      = m[5:0];
      w.second      = s[5:0];
      w.start_month = mon[3:0];
      w.start_day   = dy[4:0];
      return w;
   endfunction

   task automatic send_word(input dst_pkg::req_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req       <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sent_words++;
   endtask

   initial begin : receiver
      int mode;
      int span;
      bit held;
      held = 1'b0;
      wait (!reset);
      forever begin
         if (hold_ask && !held) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            held = 1'b1;
         end
         mode = $urandom_range(0, 4);
         span = $urandom_range(4, 40);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               2:       rsp_stall <= ($urandom_range(0, 1) == 0);
               3:       rsp_stall <= ($urandom_range(0, 3) != 0);
               4:       rsp_stall <= ($urandom_range(0, 7) == 0);
               default: rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   initial begin : stimulus
      dst_pkg::req_type w;
      int th, tm, ph, pm, mon, dy, bm, bd, em, ed, len;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(tick_word());
      w = noise_word();
      w.command = CMD_UNUSED;
      send_word(w);
      send_word(set_word(23, 59, 59, 12, 31));
      send_word(tick_word());
      send_word(set_word(31, 63, 63, 15, 31));
      send_word(tick_word());
      send_word(load_word(0, 0, 7, 30, 0, 1, 1, 12, 31));
      send_word(load_word(1, 15, 7, 30, 1, 1, 1, 12, 31));
      send_word(load_word(2, 9, 7, 30, 2, 6, 15, 6, 15));
      send_word(load_word(3, 6, 7, 30, 65535, 6, 1, 6, 30));
      send_word(load_word(4, 3, 7, 30, 3, 1, 1, 6, 14));
      send_word(load_word(5, 12, 7, 30, 5, 6, 16, 12, 31));
      send_word(load_word(6, 1, 7, 31, 4, 0, 0, 15, 31));
      send_word(load_word(7, 10, 7, 30, 1, 1, 1, 12, 31));
      send_word(set_word(7, 29, 59, 6, 15));
      repeat (3) send_word(tick_word());
      send_word(set_word(7, 30, 59, 6, 15));
      repeat (2) send_word(tick_word());
      send_word(load_word(4, 8, 7, 31, 2, 6, 15, 12, 31));
      send_word(tick_word());
      send_word(set_word(0, 0, 0, 1, 1));

      hold_ask = 1'b1;
      sent_words = 0;
      while (sent_words < RANDOM_WORDS) begin
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 3)) send_word(noise_word());
         end else begin
            th  = $urandom_range(0, 23);
            tm  = $urandom_range(0, 59);
            mon = $urandom_range(1, 12);
            dy  = $urandom_range(1, 31);
            if ($urandom_range(0, 7) == 0) begin
               th = 0;
               tm = 0;
            end
            repeat ($urandom_range(1, 3)) begin
               ph = th;
               pm = tm;
               case ($urandom_range(0, 5))
                  0:       pm = (tm + 1) % 60;
                  1:       ph = $urandom_range(0, 31);
                  default: begin
                  end
               endcase
               if ($urandom_range(0, 3) == 0) begin
                  len = $urandom_range(0, 65535);
               end else begin
                  len = $urandom_range(0, 4);
               end
               if ($urandom_range(0, 3) != 0) begin
                  bm = $urandom_range(1, mon);
                  bd = (bm == mon) ? $urandom_range(1, dy) : $urandom_range(1, 31);
                  em = $urandom_range(mon, 12);
                  ed = (em == mon) ? $urandom_range(dy, 31) : $urandom_range(1, 31);
               end else begin
                  bm = $urandom_range(0, 15);
                  bd = $urandom_range(0, 31);
                  em = $urandom_range(0, 15);
                  ed = $urandom_range(0, 31);
               end
               send_word(load_word($urandom_range(0, 7), $urandom_range(0, 15), ph, pm,
                                   len, bm, bd, em, ed));
            end
            if ($urandom_range(0, 4) == 0) begin
               send_word(set_word(th, tm, $urandom_range(0, 58), mon, dy));
            end else if (tm > 0) begin
               send_word(set_word(th, tm - 1, $urandom_range(56, 59), mon, dy));
            end else begin
               send_word(set_word((th + 23) % 24, 59, $urandom_range(56, 59), mon, dy));
            end
            repeat ($urandom_range(2, 7)) send_word(tick_word());
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
